FILE: sv/ioct_pkg.sv
`timescale 1ns / 1ps
// Package for the in-order commit tracker: field widths, command and status codes,
// and the command record passed from the front queue to the back end. No dependencies.
package ioct_pkg;

  localparam int QueueDepthDef = 16;
  localparam int SeqW          = 63;
  localparam int KindW         = 2;
  localparam int TagW          = 4;
  localparam int CountW        = 5;
  localparam int StatusW       = 2;

  // Raw kind codes on the request port.
  localparam logic [KindW-1:0] KIND_ISSUE    = 2'd0;
  localparam logic [KindW-1:0] KIND_COMPLETE = 2'd1;
  localparam logic [KindW-1:0] KIND_POLL     = 2'd2;

  typedef enum logic [1:0] {
    OP_ISSUE    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_POLL     = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_BAD_TAG = 2'd2
  } status_e;

  typedef struct packed {
    op_e             op;
    logic [SeqW-1:0] final_seq;
    logic [TagW-1:0] tag;
  } cmd_t;

endpackage

FILE: sv/ioct_front.sv
`timescale 1ns / 1ps
// Front end of the commit tracker: accepts requests, decodes the kind into an
// operation and holds them in a two-entry queue for the back end. Uses ioct_pkg.
module ioct_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ioct_pkg::KindW-1:0]    kind_i,
  input  logic [ioct_pkg::SeqW-1:0]     final_seq_i,
  input  logic [ioct_pkg::TagW-1:0]     tag_i,
  output logic                          cmd_valid_o,
  output ioct_pkg::cmd_t                cmd_o,
  input  logic                          cmd_pop_i
);
  import ioct_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  logic       pop;
  cmd_t       new_cmd;

  always_comb begin
    new_cmd.final_seq = final_seq_i;
    new_cmd.tag       = tag_i;
    case (kind_i)
      KIND_ISSUE:    new_cmd.op = OP_ISSUE;
      KIND_COMPLETE: new_cmd.op = OP_COMPLETE;
      KIND_POLL:     new_cmd.op = OP_POLL;
      default:       new_cmd.op = OP_NONE;
    endcase
  end

  assign busy_o      = (fill_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

FILE: sv/ioct_back.sv
`timescale 1ns / 1ps
// Back end of the commit tracker: slot ring, done flags, final-sequence memory,
// retirement walk and result registers. Uses ioct_pkg.
module ioct_back #(
  parameter int QueueDepth = ioct_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  ioct_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic                          valid_o,
  output logic [ioct_pkg::TagW-1:0]     slot_tag_o,
  output logic                          commit_valid_o,
  output logic [ioct_pkg::SeqW-1:0]     commit_seq_o,
  output logic [ioct_pkg::CountW-1:0]   outstanding_count_o,
  output logic [ioct_pkg::CountW-1:0]   done_waiting_count_o,
  output logic [ioct_pkg::StatusW-1:0]  status_o
);
  import ioct_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QueueDepth - 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_RETIRE = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [PtrW-1:0]       head_q, head_d;
  logic [PtrW-1:0]       tail_q, tail_d;
  logic [CntW-1:0]       live_q, live_d;
  logic [CntW-1:0]       done_cnt_q, done_cnt_d;
  logic [QueueDepth-1:0] done_q, done_d;
  logic                  cmt_none_q, cmt_none_d;
  logic [SeqW-1:0]       cmt_seq_q, cmt_seq_d;
  logic                  rep_none_q, rep_none_d;
  logic [SeqW-1:0]       rep_seq_q, rep_seq_d;

  logic [SeqW-1:0]       final_mem [QueueDepth];
  logic [SeqW-1:0]       rd_data_q;
  logic                  mem_we;

  logic                  res_fire;
  logic [TagW-1:0]       res_slot;
  logic                  res_cv;
  logic [SeqW-1:0]       res_cs;
  status_e               res_stat;

  logic                  valid_q;
  logic [TagW-1:0]       slot_q;
  logic                  cv_q;
  logic [SeqW-1:0]       cs_q;
  logic [CountW-1:0]     live_out_q;
  logic [CountW-1:0]     done_out_q;
  status_e               stat_q;

  logic [PtrW-1:0]       tag_idx;
  logic                  tag_in_range;
  logic [PtrW:0]         tag_off;

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    ring_next = (p == LastSlot) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    tag_idx      = PtrW'(cmd_i.tag);
    tag_in_range = (int'(cmd_i.tag) < QueueDepth);
    if (tag_idx >= head_q) begin
      tag_off = {1'b0, tag_idx} - {1'b0, head_q};
    end else begin
      tag_off = (PtrW + 1)'(QueueDepth) + {1'b0, tag_idx} - {1'b0, head_q};
    end
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    live_d     = live_q;
    done_cnt_d = done_cnt_q;
    done_d     = done_q;
    cmt_none_d = cmt_none_q;
    cmt_seq_d  = cmt_seq_q;
    rep_none_d = rep_none_q;
    rep_seq_d  = rep_seq_q;
    mem_we     = 1'b0;
    cmd_pop_o  = 1'b0;
    res_fire   = 1'b0;
    res_slot   = '0;
    res_cv     = 1'b0;
    res_cs     = '0;
    res_stat   = STAT_OK;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          res_fire  = 1'b1;
          case (cmd_i.op)
            OP_ISSUE: begin
              if (live_q == CntW'(QueueDepth)) begin
                res_stat = STAT_FULL;
              end else begin
                mem_we         = 1'b1;
                done_d[tail_q] = 1'b0;
                res_slot       = TagW'(tail_q);
                tail_d         = ring_next(tail_q);
                live_d         = live_q + 1'b1;
              end
            end
            OP_COMPLETE: begin
              if (!tag_in_range) begin
                res_stat = STAT_BAD_TAG;
              end else if (tag_off >= (PtrW + 1)'(live_q) || done_q[tag_idx]) begin
                res_stat = STAT_BAD_TAG;
              end else if (tag_idx != head_q) begin
                done_d[tag_idx] = 1'b1;
                done_cnt_d      = done_cnt_q + 1'b1;
              end else begin
                // The head finished: walk the ring one slot per cycle.
                res_fire = 1'b0;
                state_d  = ST_RETIRE;
              end
            end
            OP_POLL: begin
              if ((cmt_none_q != rep_none_q) || (!cmt_none_q && cmt_seq_q != rep_seq_q)) begin
                res_cv     = 1'b1;
                res_cs     = cmt_seq_q;
                rep_none_d = cmt_none_q;
                rep_seq_d  = cmt_seq_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RETIRE: begin
        // The memory read of the head slot was issued in the previous cycle.
        cmt_none_d     = 1'b0;
        cmt_seq_d      = rd_data_q;
        done_d[head_q] = 1'b0;
        if (done_q[head_q]) begin
          done_cnt_d = done_cnt_q - 1'b1;
        end
        head_d = ring_next(head_q);
        live_d = live_q - 1'b1;
        if (live_d == '0 || !done_q[head_d]) begin
          res_fire = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      live_q     <= '0;
      done_cnt_q <= '0;
      done_q     <= '0;
      cmt_none_q <= 1'b1;
      cmt_seq_q  <= '0;
      rep_none_q <= 1'b1;
      rep_seq_q  <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      live_q     <= live_d;
      done_cnt_q <= done_cnt_d;
      done_q     <= done_d;
      cmt_none_q <= cmt_none_d;
      cmt_seq_q  <= cmt_seq_d;
      rep_none_q <= rep_none_d;
      rep_seq_q  <= rep_seq_d;
      valid_q    <= res_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      final_mem[tail_q] <= cmd_i.final_seq;
    end
    rd_data_q <= final_mem[head_d];
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      slot_q     <= res_slot;
      cv_q       <= res_cv;
      cs_q       <= res_cs;
      live_out_q <= CountW'(live_d);
      done_out_q <= CountW'(done_cnt_d);
      stat_q     <= res_stat;
    end
  end

  assign valid_o              = valid_q;
  assign slot_tag_o           = slot_q;
  assign commit_valid_o       = cv_q;
  assign commit_seq_o         = cs_q;
  assign outstanding_count_o  = live_out_q;
  assign done_waiting_count_o = done_out_q;
  assign status_o             = stat_q;

endmodule

FILE: sv/in_order_commit_tracker.sv
`timescale 1ns / 1ps
// In-order commit tracker top level. Depends on ioct_pkg, ioct_front and ioct_back.
// A request waits in the front queue until the back end decodes it and registers its
// result, which strobes valid_o; a completion of the oldest batch first walks the
// ring in order. Throughput: one request per cycle while no walk runs; the two-entry
// front queue takes requests during a walk until it fills. The receiver cannot stall.
// Reset clears pointers, counts, done flags and commit state at once; no clearing pass.
module in_order_commit_tracker #(
  parameter int QueueDepth = ioct_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ioct_pkg::KindW-1:0]    kind_i,
  input  logic [ioct_pkg::SeqW-1:0]     first_seq_i,
  input  logic [ioct_pkg::SeqW-1:0]     final_seq_i,
  input  logic [ioct_pkg::TagW-1:0]     tag_i,
  output logic                          valid_o,
  output logic [ioct_pkg::TagW-1:0]     slot_tag_o,
  output logic                          commit_valid_o,
  output logic [ioct_pkg::SeqW-1:0]     commit_seq_o,
  output logic [ioct_pkg::CountW-1:0]   outstanding_count_o,
  output logic [ioct_pkg::CountW-1:0]   done_waiting_count_o,
  output logic [ioct_pkg::StatusW-1:0]  status_o
);
  import ioct_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // The first sequence number of a batch never reaches a result, so it is not kept.
  ioct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .kind_i      (kind_i),
    .final_seq_i (final_seq_i),
    .tag_i       (tag_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ioct_back #(
    .QueueDepth (QueueDepth)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_valid_i          (cmd_valid),
    .cmd_i                (cmd),
    .cmd_pop_o            (cmd_pop),
    .valid_o              (valid_o),
    .slot_tag_o           (slot_tag_o),
    .commit_valid_o       (commit_valid_o),
    .commit_seq_o         (commit_seq_o),
    .outstanding_count_o  (outstanding_count_o),
    .done_waiting_count_o (done_waiting_count_o),
    .status_o             (status_o)
  );

endmodule

FILE: sv/ioct_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the in-order commit tracker, bound to the top level.
// Depends on ioct_pkg and in_order_commit_tracker.
module ioct_checker #(
  parameter int QueueDepth = ioct_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_o,
  input  logic [ioct_pkg::TagW-1:0]     slot_tag_o,
  input  logic                          commit_valid_o,
  input  logic [ioct_pkg::SeqW-1:0]     commit_seq_o,
  input  logic [ioct_pkg::CountW-1:0]   outstanding_count_o,
  input  logic [ioct_pkg::CountW-1:0]   done_waiting_count_o,
  input  logic [ioct_pkg::StatusW-1:0]  status_o
);
  import ioct_pkg::*;

  localparam bit CountsFit = (QueueDepth < 32);

  // A rejected request never reports a commit.
  a_err_no_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != STAT_OK |-> !commit_valid_o)
    else $error("commit reported with an error status");

  a_seq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !commit_valid_o |-> commit_seq_o == '0)
    else $error("commit sequence not zero without a commit");

  // A full queue means every slot is outstanding and no slot was given out.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == STAT_FULL |->
      outstanding_count_o == CountW'(QueueDepth) && slot_tag_o == '0)
    else $error("queue full reported with free slots");

  a_done_le_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && CountsFit |-> done_waiting_count_o < outstanding_count_o ||
      done_waiting_count_o == '0)
    else $error("more finished batches waiting than outstanding");

endmodule

bind in_order_commit_tracker ioct_checker #(
  .QueueDepth (QueueDepth)
) u_ioct_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .valid_o              (valid_o),
  .slot_tag_o           (slot_tag_o),
  .commit_valid_o       (commit_valid_o),
  .commit_seq_o         (commit_seq_o),
  .outstanding_count_o  (outstanding_count_o),
  .done_waiting_count_o (done_waiting_count_o),
  .status_o             (status_o)
);

FILE: tb/in_order_commit_tracker_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for in_order_commit_tracker: directed and random requests,
// each result checked against an in-bench commit predictor. Depends on ioct_pkg.
module in_order_commit_tracker_tb;
  import ioct_pkg::*;

  localparam int Depth      = QueueDepthDef;
  localparam int CycleLimit = 400000;
  localparam int ExpDepth   = 64;

  typedef struct {
    logic [TagW-1:0]   slot;
    logic              cvalid;
    logic [SeqW-1:0]   cseq;
    logic [CountW-1:0] outst;
    logic [CountW-1:0] waiting;
    status_e           status;
  } commit_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [KindW-1:0]    kind_i = '0;
  logic [SeqW-1:0]     first_seq_i = '0;
  logic [SeqW-1:0]     final_seq_i = '0;
  logic [TagW-1:0]     tag_i = '0;
  logic                valid_o;
  logic [TagW-1:0]     slot_tag_o;
  logic                commit_valid_o;
  logic [SeqW-1:0]     commit_seq_o;
  logic [CountW-1:0]   outstanding_count_o;
  logic [CountW-1:0]   done_waiting_count_o;
  logic [StatusW-1:0]  status_o;

  in_order_commit_tracker dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .kind_i               (kind_i),
    .first_seq_i          (first_seq_i),
    .final_seq_i          (final_seq_i),
    .tag_i                (tag_i),
    .valid_o              (valid_o),
    .slot_tag_o           (slot_tag_o),
    .commit_valid_o       (commit_valid_o),
    .commit_seq_o         (commit_seq_o),
    .outstanding_count_o  (outstanding_count_o),
    .done_waiting_count_o (done_waiting_count_o),
    .status_o             (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: a copy of the ring and the commit bookkeeping.
  logic [SeqW-1:0] ring_final [Depth];
  logic            ring_done [Depth];
  int              ring_head;
  int              ring_tail;
  int              ring_live;
  logic [63:0]     committed;
  logic [63:0]     reported;

  // Expected results in request order, kept in a ring indexed by running counts.
  commit_result_t  exp_fifo [ExpDepth];
  int              exp_wr_cnt;
  int              exp_rd_cnt;
  commit_result_t  seen_exp;
  int              error_count;
  int              request_count;
  int              result_count;
  int              commit_count;
  int              full_count;
  int              bad_tag_count;
  int              longest_walk;
  int              cycle_count;
  int              idle_mode;
  logic [SeqW-1:0] next_seq;

  task automatic retire_oldest();
    committed = {1'b0, ring_final[ring_head]};
    ring_done[ring_head] = 1'b0;
    ring_head = (ring_head + 1) % Depth;
    ring_live--;
  endtask

  task automatic predict_commit(input op_e k, input logic [SeqW-1:0] fn,
                                input logic [TagW-1:0] tg, output commit_result_t res);
    int off;
    int walk;
    int n_done;
    res.slot = '0;
    res.cvalid = 1'b0;
    res.cseq = '0;
    res.status = STAT_OK;
    case (k)
      OP_ISSUE: begin
        if (ring_live >= Depth) begin
          res.status = STAT_FULL;
          full_count++;
        end else begin
          ring_final[ring_tail] = fn;
          ring_done[ring_tail] = 1'b0;
          res.slot = TagW'(ring_tail);
          ring_tail = (ring_tail + 1) % Depth;
          ring_live++;
        end
      end
      OP_COMPLETE: begin
        off = (int'(tg) + Depth - ring_head) % Depth;
        if (int'(tg) >= Depth || off >= ring_live || ring_done[tg]) begin
          res.status = STAT_BAD_TAG;
          bad_tag_count++;
        end else if (int'(tg) != ring_head) begin
          ring_done[tg] = 1'b1;
        end else begin
          retire_oldest();
          walk = 1;
          while (ring_live > 0 && ring_done[ring_head]) begin
            retire_oldest();
            walk++;
          end
          if (walk > longest_walk) longest_walk = walk;
        end
      end
      OP_POLL: begin
        if (committed != reported) begin
          res.cvalid = 1'b1;
          res.cseq = committed[SeqW-1:0];
          reported = committed;
          commit_count++;
        end
      end
      default: ;
    endcase
    n_done = 0;
    for (int i = 0; i < ring_live; i++) begin
      if (ring_done[(ring_head + i) % Depth]) n_done++;
    end
    res.outst = CountW'(ring_live);
    res.waiting = CountW'(n_done);
  endtask

  function automatic logic [SeqW-1:0] rand_seq();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[SeqW-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_mode == 0 || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one request and holds it until the block takes it.
  task automatic send_request(input op_e k, input logic [SeqW-1:0] fs,
                              input logic [SeqW-1:0] fn, input logic [TagW-1:0] tg);
    commit_result_t res;
    int gap;
    @(negedge clk_i);
    start_i     <= 1'b1;
    kind_i      <= k;
    first_seq_i <= fs;
    final_seq_i <= fn;
    tag_i       <= tg;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    predict_commit(k, fn, tg, res);
    exp_fifo[exp_wr_cnt % ExpDepth] = res;
    exp_wr_cnt++;
    if (k != OP_NONE) request_count++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic issue_batch(input logic [SeqW-1:0] fs, input logic [SeqW-1:0] fn);
    send_request(OP_ISSUE, fs, fn, TagW'($urandom()));
  endtask

  task automatic complete_batch(input logic [TagW-1:0] tg);
    send_request(OP_COMPLETE, rand_seq(), rand_seq(), tg);
  endtask

  task automatic poll_commit();
    send_request(OP_POLL, rand_seq(), rand_seq(), TagW'($urandom()));
  endtask

  // Extremes of the sequence fields, every request kind and the bad-tag cases.
  task automatic test_directed();
    idle_mode = 0;
    poll_commit();
    send_request(OP_NONE, '1, '1, '1);
    complete_batch(4'd0);
    issue_batch('0, '0);
    issue_batch('1, '1);
    issue_batch(63'd5, 63'd9);
    complete_batch(4'd2);
    complete_batch(4'd2);
    complete_batch(4'd7);
    complete_batch(4'd0);
    poll_commit();
    poll_commit();
    complete_batch(4'd1);
    poll_commit();
    issue_batch('0, '1);
    complete_batch(4'd3);
    poll_commit();
  endtask

  // Fill the ring, overflow it once, then finish everything but the oldest
  // batch so its completion retires the whole ring in one walk.
  task automatic test_full_ring();
    int order [Depth];
    int n_order;
    int j;
    int tmp;
    idle_mode = 1;
    while (ring_live < Depth) begin
      issue_batch(next_seq, next_seq + 63'(ring_live));
      next_seq = next_seq + 63'(ring_live) + 63'd1;
    end
    issue_batch(rand_seq(), rand_seq());
    n_order = 0;
    for (int i = 1; i < Depth; i++) begin
      order[n_order] = (ring_head + i) % Depth;
      n_order++;
    end
    for (int i = n_order - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < n_order; i++) complete_batch(TagW'(order[i]));
    complete_batch(TagW'(ring_head));
    poll_commit();
  endtask

  // Mostly well-formed traffic: issues of consecutive ranges, polls and completions of
  // live, unfinished slots, with some random ranges, tags and no-op requests mixed in.
  task automatic test_random_traffic(input int n_items, input int issue_pct,
                                     input int mode);
    int target;
    int r;
    int cand [Depth];
    int n_cand;
    int p;
    logic [SeqW-1:0] span;
    idle_mode = mode;
    target = request_count + n_items;
    while (request_count < target) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_request(OP_NONE, rand_seq(), rand_seq(), TagW'($urandom()));
      end else if (r < 4 + issue_pct) begin
        if ($urandom_range(0, 9) == 0) begin
          issue_batch(rand_seq(), rand_seq());
        end else begin
          if ($urandom_range(0, 49) == 0) next_seq = '1 - 63'($urandom_range(0, 200));
          span = 63'($urandom_range(0, 1000));
          issue_batch(next_seq, next_seq + span);
          next_seq = next_seq + span + 63'd1;
        end
      end else if (r < 86) begin
        if (ring_live > 0 && $urandom_range(0, 9) != 0) begin
          n_cand = 0;
          for (int i = 0; i < ring_live; i++) begin
            p = (ring_head + i) % Depth;
            if (!ring_done[p]) begin
              cand[n_cand] = p;
              n_cand++;
            end
          end
          complete_batch(TagW'(cand[$urandom_range(0, n_cand - 1)]));
        end else begin
          complete_batch(TagW'($urandom()));
        end
      end else begin
        poll_commit();
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      result_count++;
      if (exp_wr_cnt == exp_rd_cnt) begin
        error_count++;
        $display("%0t: result with no request outstanding (status %0d, count %0d)",
                 $time, status_o, outstanding_count_o);
      end else begin
        seen_exp = exp_fifo[exp_rd_cnt % ExpDepth];
        exp_rd_cnt++;
        if (slot_tag_o !== seen_exp.slot) begin
          error_count++;
          $display("%0t: slot_tag expected %0d, actual %0d", $time, seen_exp.slot,
                   slot_tag_o);
        end
        if (commit_valid_o !== seen_exp.cvalid) begin
          error_count++;
          $display("%0t: commit_valid expected %0b, actual %0b", $time, seen_exp.cvalid,
                   commit_valid_o);
        end
        if (commit_seq_o !== seen_exp.cseq) begin
          error_count++;
          $display("%0t: commit_seq expected %h, actual %h", $time, seen_exp.cseq,
                   commit_seq_o);
        end
        if (outstanding_count_o !== seen_exp.outst) begin
          error_count++;
          $display("%0t: outstanding_count expected %0d, actual %0d", $time,
                   seen_exp.outst, outstanding_count_o);
        end
        if (done_waiting_count_o !== seen_exp.waiting) begin
          error_count++;
          $display("%0t: done_waiting_count expected %0d, actual %0d", $time,
                   seen_exp.waiting, done_waiting_count_o);
        end
        if (status_o !== seen_exp.status) begin
          error_count++;
          $display("%0t: status expected %0d, actual %0d", $time, seen_exp.status,
                   status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               exp_wr_cnt - exp_rd_cnt);
      $display("FAIL in_order_commit_tracker");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Depth; i++) begin
      ring_final[i] = '0;
      ring_done[i] = 1'b0;
    end
    ring_head = 0;
    ring_tail = 0;
    ring_live = 0;
    committed = '1;
    reported = '1;
    exp_wr_cnt = 0;
    exp_rd_cnt = 0;
    error_count = 0;
    request_count = 0;
    result_count = 0;
    commit_count = 0;
    full_count = 0;
    bad_tag_count = 0;
    longest_walk = 0;
    cycle_count = 0;
    idle_mode = 0;
    next_seq = rand_seq() >> 2;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_full_ring();
    test_random_traffic(220, 55, 1);
    test_random_traffic(180, 40, 0);
    test_random_traffic(180, 25, 1);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (exp_wr_cnt != exp_rd_cnt) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d results in %0d cycles.", request_count,
             result_count, cycle_count);
    $display("Saw %0d commits, %0d full-ring issues, %0d bad tags, longest walk %0d.",
             commit_count, full_count, bad_tag_count, longest_walk);
    if (error_count == 0) begin
      $display("PASS in_order_commit_tracker");
    end else begin
      $display("FAIL in_order_commit_tracker");
    end
    $finish;
  end

endmodule
